// ===== hdl/lpba_pkg.sv =====
// Package for the lidar point box assignment block.
// Holds command codes, field widths and the controller/datapath command structs.
// No dependencies.
package lpba_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned COEF_W   = 32;
    localparam int unsigned BOX_W    = 12;
    localparam int unsigned PT_W     = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned PIX_W    = 16;
    localparam int unsigned SUM_W    = 52;
    localparam int unsigned NUM_COEF = 12;
    localparam int unsigned QUO_W    = 17;

    localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_BOX  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROJECT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE     = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEVERAL = 2'd2;

    localparam logic [15:0] SHRINK_RESET = 16'd6554;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       capture;    // latch input item
        logic       mac_clr;    // clear row accumulators
        logic       mac_step;   // one multiply-accumulate term
        logic [1:0] mac_term;   // which column term
        logic       div_start;  // load divider for both quotients
        logic       div_step;   // one quotient bit
        logic       div_fin;    // apply sign and saturate
        logic       scan_clr;
        logic       scan_step;  // test one box
        logic       res_load;   // move result to output register
    } t_dp_cmd;

    typedef struct packed {
        logic zero_depth;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== hdl/lpba_if.sv =====
// Valid/ready channel interfaces for the lidar point box assignment block.
// Depends on lpba_pkg.
interface lpba_in_if;
    logic                              valid;
    logic                              ready;
    logic [lpba_pkg::CMD_W-1:0]        cmd;
    logic [lpba_pkg::SLOT_W-1:0]       slot;
    logic signed [lpba_pkg::COEF_W-1:0] coef_value;
    logic [lpba_pkg::BOX_W-1:0]        box_left;
    logic [lpba_pkg::BOX_W-1:0]        box_top;
    logic [lpba_pkg::BOX_W-1:0]        box_width;
    logic [lpba_pkg::BOX_W-1:0]        box_height;
    logic signed [lpba_pkg::PT_W-1:0]  point_x;
    logic signed [lpba_pkg::PT_W-1:0]  point_y;
    logic signed [lpba_pkg::PT_W-1:0]  point_z;
    modport source (output valid, cmd, slot, coef_value, box_left, box_top, box_width,
                    box_height, point_x, point_y, point_z, input ready);
    modport sink (input valid, cmd, slot, coef_value, box_left, box_top, box_width,
                  box_height, point_x, point_y, point_z, output ready);
endinterface

interface lpba_out_if;
    logic                              valid;
    logic                              ready;
    logic [lpba_pkg::KIND_W-1:0]       match_kind;
    logic [lpba_pkg::SLOT_W-1:0]       box_index;
    logic signed [lpba_pkg::PIX_W-1:0] pixel_u;
    logic signed [lpba_pkg::PIX_W-1:0] pixel_v;
    modport source (output valid, match_kind, box_index, pixel_u, pixel_v, input ready);
    modport sink (input valid, match_kind, box_index, pixel_u, pixel_v, output ready);
endinterface

// ===== hdl/lpba_datapath.sv =====
// Datapath: coefficient and box stores, row accumulators, restoring divider, box scanner.
// Depends on lpba_pkg; driven by lpba_ctrl through t_dp_cmd.
module lpba_datapath #(
    parameter int unsigned MAX_BOXES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [15:0]                 i_cfg_data,
    input  lpba_pkg::t_dp_cmd           i_cmd,
    output lpba_pkg::t_dp_stat          o_stat,
    input  logic [lpba_pkg::CMD_W-1:0]  i_in_cmd,
    input  logic [lpba_pkg::SLOT_W-1:0] i_in_slot,
    input  logic [31:0]                 i_coef,
    input  logic [4*lpba_pkg::BOX_W-1:0] i_box,
    input  logic [3*lpba_pkg::PT_W-1:0] i_point,
    output logic [1:0]                  o_kind,
    output logic [3:0]                  o_index,
    output logic [15:0]                 o_u,
    output logic [15:0]                 o_v
);
    localparam int unsigned SW    = lpba_pkg::SUM_W;
    localparam int unsigned CW    = $clog2(MAX_BOXES + 1);
    localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    logic signed [31:0] r_mat [lpba_pkg::NUM_COEF];
    logic [47:0]        r_box [MAX_BOXES];
    logic [15:0]        r_shrink;
    logic [CW-1:0]      r_count;
    logic signed [15:0] r_px, r_py, r_pz;
    logic signed [SW-1:0] r_su, r_sv, r_sd;

    // Shrink factor and saturated box count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shrink <= lpba_pkg::SHRINK_RESET;
            r_count  <= '0;
        end else if (i_cfg_we) begin
            if (!i_cfg_idx) begin
                r_shrink <= i_cfg_data;
            end else if (32'(i_cfg_data[4:0]) > MAX_BOXES) begin
                r_count <= CW'(MAX_BOXES);
            end else begin
                r_count <= CW'(i_cfg_data[4:0]);
            end
        end
    end

    // Stores and point capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if (i_in_cmd == lpba_pkg::CMD_LOAD_COEF && i_in_slot < 4'(lpba_pkg::NUM_COEF)) begin
                r_mat[i_in_slot] <= i_coef;
            end
            if (i_in_cmd == lpba_pkg::CMD_LOAD_BOX && 32'(i_in_slot) < MAX_BOXES) begin
                r_box[IDX_W'(i_in_slot)] <= i_box;
            end
            r_px <= i_point[47:32];
            r_py <= i_point[31:16];
            r_pz <= i_point[15:0];
        end
    end

    // One term per step for each row; three 32x16 multipliers.
    logic signed [15:0] w_term;
    always_comb begin
        case (i_cmd.mac_term)
            2'd0:    w_term = r_px;
            2'd1:    w_term = r_py;
            2'd2:    w_term = r_pz;
            default: w_term = 16'sd256;
        endcase
    end
    logic signed [47:0] w_pu, w_pv, w_pd;
    assign w_pu = r_mat[{2'd0, i_cmd.mac_term}] * w_term;
    assign w_pv = r_mat[{2'd1, i_cmd.mac_term}] * w_term;
    assign w_pd = r_mat[{2'd2, i_cmd.mac_term}] * w_term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_clr) begin
            r_su <= '0;
            r_sv <= '0;
            r_sd <= '0;
        end else if (i_cmd.mac_step) begin
            r_su <= r_su + SW'(w_pu);
            r_sv <= r_sv + SW'(w_pv);
            r_sd <= r_sd + SW'(w_pd);
        end
    end
    logic w_zero_depth;
    assign w_zero_depth = (r_sd == '0);

    // Restoring division of (2a+b) by 2b, two quotients share the divisor.
    localparam int unsigned DW = SW + 2;
    localparam int unsigned QUO_W_L = lpba_pkg::QUO_W;
    logic [DW-1:0] r_den, r_ru, r_rv, r_nu, r_nv;
    logic [QUO_W_L-1:0] r_qu, r_qv;
    logic r_neg_u, r_neg_v;
    logic [SW-1:0] w_au, w_av, w_b;
    assign w_au = r_su[SW-1] ? SW'(-r_su) : SW'(r_su);
    assign w_av = r_sv[SW-1] ? SW'(-r_sv) : SW'(r_sv);
    assign w_b  = r_sd[SW-1] ? SW'(-r_sd) : SW'(r_sd);

    // Overflow flag catches quotient bits shifted out beyond 17 bits; w_tu/w_tv bring in the next numerator bit.
    logic [DW-1:0] w_tu, w_tv;
    logic r_ovu, r_ovv;
    assign w_tu = {r_ru[DW-2:0], r_nu[DW-1]};
    assign w_tv = {r_rv[DW-2:0], r_nv[DW-1]};

    logic [SW-1:0] w_b_dummy;
    assign w_b_dummy = w_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_den   <= {w_b_dummy, 1'b0, 1'b0} >> 1;
            r_nu    <= ({2'b00, w_au} << 1) + {2'b00, w_b};
            r_nv    <= ({2'b00, w_av} << 1) + {2'b00, w_b};
            r_ru    <= '0;
            r_rv    <= '0;
            r_qu    <= '0;
            r_qv    <= '0;
            r_ovu   <= 1'b0;
            r_ovv   <= 1'b0;
            r_neg_u <= r_su[SW-1] ^ r_sd[SW-1];
            r_neg_v <= r_sv[SW-1] ^ r_sd[SW-1];
        end else if (i_cmd.div_step) begin
            r_nu <= r_nu << 1;
            r_nv <= r_nv << 1;
            if (w_tu >= r_den) begin
                r_ru <= w_tu - r_den;
                r_qu <= {r_qu[QUO_W_L-2:0], 1'b1};
                r_ovu <= r_ovu | r_qu[QUO_W_L-1];
            end else begin
                r_ru <= w_tu;
                r_qu <= {r_qu[QUO_W_L-2:0], 1'b0};
                r_ovu <= r_ovu | r_qu[QUO_W_L-1];
            end
            if (w_tv >= r_den) begin
                r_rv <= w_tv - r_den;
                r_qv <= {r_qv[QUO_W_L-2:0], 1'b1};
                r_ovv <= r_ovv | r_qv[QUO_W_L-1];
            end else begin
                r_rv <= w_tv;
                r_qv <= {r_qv[QUO_W_L-2:0], 1'b0};
                r_ovv <= r_ovv | r_qv[QUO_W_L-1];
            end
        end
    end

    // Full DW-bit divide would need DW steps; the controller runs DW steps.
    function automatic logic signed [15:0] sat16(input logic [QUO_W_L-1:0] q,
                                                 input logic ov, input logic neg);
        logic big;
        big = ov || (neg ? (q > 17'd32768) : (q > 17'd32767));
        if (neg) begin
            sat16 = big ? 16'sh8000 : 16'(-q);
        end else begin
            sat16 = big ? 16'sh7fff : 16'(q);
        end
    endfunction

    logic signed [15:0] r_u, r_v;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_fin) begin
            r_u <= sat16(r_qu, r_ovu, r_neg_u);
            r_v <= sat16(r_qv, r_ovv, r_neg_v);
        end
    end

    // Box scan, one slot a cycle.
    logic [IDX_W:0] r_bi;
    logic [1:0]     r_hits;
    logic [3:0]     r_idx;
    logic [11:0] w_l, w_t, w_w, w_h;
    assign {w_l, w_t, w_w, w_h} = r_box[IDX_W'(r_bi)];
    logic [27:0] w_sw, w_sh, w_iw, w_ih;
    logic [16:0] w_inv;
    assign w_inv = 17'h10000 - {1'b0, r_shrink};
    assign w_sw = r_shrink * w_w;
    assign w_sh = r_shrink * w_h;
    assign w_iw = 28'(w_inv * w_w);
    assign w_ih = 28'(w_inv * w_h);
    logic signed [17:0] w_l2, w_t2, w_r2, w_b2;
    assign w_l2 = 18'(w_l) + 18'(w_sw[27:17]);
    assign w_t2 = 18'(w_t) + 18'(w_sh[27:17]);
    assign w_r2 = w_l2 + 18'(w_iw[27:16]);
    assign w_b2 = w_t2 + 18'(w_ih[27:16]);
    logic w_in;
    assign w_in = (w_l2 <= 18'(r_u)) && (18'(r_u) < w_r2) &&
                  (w_t2 <= 18'(r_v)) && (18'(r_v) < w_b2) && (CW'(r_bi) < r_count);
    logic w_scan_last;
    assign w_scan_last = (32'(r_bi) >= MAX_BOXES - 1);

    assign o_stat = '{zero_depth: w_zero_depth, scan_last: w_scan_last};

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_bi   <= '0;
            r_hits <= '0;
            r_idx  <= '0;
        end else if (i_cmd.scan_step) begin
            r_bi <= r_bi + 1'b1;
            if (w_in) begin
                if (r_hits == 2'd0) r_idx <= 4'(r_bi);
                if (r_hits != 2'd2) r_hits <= r_hits + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            if (r_sd == '0) begin
                o_kind  <= lpba_pkg::KIND_NONE;
                o_index <= '0;
                o_u     <= '0;
                o_v     <= '0;
            end else begin
                o_kind  <= (r_hits == 2'd0) ? lpba_pkg::KIND_NONE :
                           (r_hits == 2'd1) ? lpba_pkg::KIND_ONE : lpba_pkg::KIND_SEVERAL;
                o_index <= (r_hits == 2'd1) ? r_idx : 4'd0;
                o_u     <= r_u;
                o_v     <= r_v;
            end
        end
    end
endmodule

// ===== hdl/lpba_ctrl.sv =====
// Controller state machine: sequences capture, accumulate, divide, scan and output.
// Depends on lpba_pkg.
module lpba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [lpba_pkg::CMD_W-1:0] i_in_cmd,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lpba_pkg::t_dp_cmd          o_cmd,
    input  lpba_pkg::t_dp_stat         i_stat
);
    localparam logic [2:0] S_IDLE = 3'd0, S_MAC = 3'd1, S_DIVS = 3'd2, S_DIV = 3'd3,
                           S_FIN = 3'd4, S_SCAN = 3'd5, S_RES = 3'd6;
    localparam int unsigned DSTEPS = lpba_pkg::SUM_W + 2;

    logic [2:0] r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.mac_clr = 1'b1;
                    n_cnt = '0;
                    if (i_in_cmd == lpba_pkg::CMD_PROJECT) n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                o_cmd.mac_term = r_cnt[1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 7'd3) n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_cnt = '0;
                n_state = i_stat.zero_depth ? S_RES : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 7'(DSTEPS - 1)) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.div_fin  = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_RES;
            end
            S_RES: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.div_step && o_cmd.scan_step)) else $error("divide and scan overlap");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_ovalid || i_out_ready)) else $error("result overwritten");
    a_res_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> r_ovalid) else $error("result not presented");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_in_ready) else $error("input taken mid-divide");
endmodule

// ===== hdl/lidar_point_box_assignment_top.sv =====
// Lidar point box assignment: one input channel, one result channel, config write port.
// Items load matrix coefficients or boxes, or project a point to a pixel and find
// its enclosing box. Loads are stored when taken and give no result.
// A projection runs these steps in order before its result is presented:
// 4 multiply-accumulate steps, 1 divider load, a 54-step restoring divider for
// both pixel coordinates, a sign/saturate step, one box per cycle, an output load.
// The next item is taken after the output load.
// A point at zero depth skips divide and scan and goes straight to the output load.
// The divider and the box scan set the rate; one item is in work at a time.
// The result sits in an output register; a new item is taken while it waits,
// and a stalled receiver only holds the block once the next result is ready.
// Reset (synchronous, active low) restores shrink factor 6554 and box count 0;
// matrix and box stores are undefined until loaded.
// The user must write configuration only while idle; the block does not enforce it: index 0 shrink factor, 1 box count.
// Depends on lpba_pkg, lpba_if, lpba_ctrl, lpba_datapath.
module lidar_point_box_assignment_top #(
    parameter int unsigned MAX_BOXES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    lpba_in_if.sink     in_ch,
    lpba_out_if.source  out_ch
);
    lpba_pkg::t_dp_cmd  w_cmd;
    lpba_pkg::t_dp_stat w_stat;

    lpba_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_in_cmd   (in_ch.cmd),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    lpba_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_in_cmd (in_ch.cmd),
        .i_in_slot(in_ch.slot),
        .i_coef   (in_ch.coef_value),
        .i_box    ({in_ch.box_left, in_ch.box_top, in_ch.box_width, in_ch.box_height}),
        .i_point  ({in_ch.point_x, in_ch.point_y, in_ch.point_z}),
        .o_kind   (out_ch.match_kind),
        .o_index  (out_ch.box_index),
        .o_u      (out_ch.pixel_u),
        .o_v      (out_ch.pixel_v)
    );
endmodule
